/* sv/ptsa_pkg.sv */
// Shared types and codes for the process tree slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ptsa_pkg;

    // Operation codes carried on the opcode port
    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_CREATE  = 2'd1,
        OP_DESTROY = 2'd2,
        OP_CLEAR   = 2'd3
    } opcode_t;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture a new command transfer
        logic exec;        // apply the operation (or seed the closure)
        logic close_step;  // one descendant closure pass
        logic commit;      // free the closed set and post the result
    } ptsa_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        opcode_t op;       // latched operation
        logic    present;  // target slot in range and in use
        logic    grew;     // closure pass found new descendants
    } ptsa_stat_t;

endpackage

/* sv/process_tree_slot_allocator.sv */
// Process tree slot allocator: a table of NUM_SLOTS process slots with
// used marks and parent links.
//
// Command channel: opcode and target_index are taken at a rising edge with
// start high and busy low. Opcodes: init root, create child, destroy
// descendants, clear all.
// Result channel: done is high for exactly one cycle with status,
// new_index and freed_mask valid; the receiver takes it at the edge that
// ends that cycle and cannot hold it off.
// For init, create, clear and any rejected command, the controller goes
// from the execute state to the done state. A destroy of a present slot
// passes through the closure state in between, which covers the subtree
// below the target (depth at most NUM_SLOTS-1): the closure unit walks
// one tree level per cycle over all slots in parallel, and the pass that
// finds no new descendant frees them and posts the result.
// One command at a time: busy stays high until done; a new command can be
// accepted in the cycle after done.
// Reset: all slots free, controller idle. The parent table is not
// cleared; a slot's parent is only read while the slot is in use.
`timescale 1ns / 1ps

module process_tree_slot_allocator
    import ptsa_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [3:0]  target_index,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  new_index,
    output logic [15:0] freed_mask
);

    ptsa_cmd_t  cmd;
    ptsa_stat_t stat;

    // Controller
    ptsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath
    ptsa_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .target_index (target_index),
        .stat         (stat),
        .status       (status),
        .new_index    (new_index),
        .freed_mask   (freed_mask)
    );

endmodule

/* sv/ptsa_ctrl.sv */
// Controller state machine for the process tree slot allocator.
// Depends on ptsa_pkg; drives ptsa_datapath through command/status structs.
`timescale 1ns / 1ps

module ptsa_ctrl
    import ptsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  ptsa_stat_t stat,
    output ptsa_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.op == OP_DESTROY && stat.present)
                begin
                    state_next = S_CLOSE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLOSE:
            begin
                if (!stat.grew)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_CLOSE:
            begin
                cmd.close_step = 1'b1;
                cmd.commit     = !stat.grew;
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* sv/ptsa_datapath.sv */
// Datapath for the process tree slot allocator: slot table, free-slot
// finder, descendant closure and result registers. Depends on ptsa_pkg.
`timescale 1ns / 1ps

module ptsa_datapath
    import ptsa_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ptsa_cmd_t   cmd,
    input  logic [1:0]  opcode,
    input  logic [3:0]  target_index,
    output ptsa_stat_t  stat,
    output logic [1:0]  status,
    output logic [3:0]  new_index,
    output logic [15:0] freed_mask
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W  = (SLOT_W > 4) ? SLOT_W : 4;
    localparam int MASK_W = (NUM_SLOTS > 16) ? NUM_SLOTS : 16;

    // Latched command
    opcode_t              op_reg;
    logic [3:0]           tgt_reg;

    // Slot table
    logic [NUM_SLOTS-1:0] used_reg;
    logic [SLOT_W-1:0]    parent_reg [NUM_SLOTS];

    // Closure sets
    logic [NUM_SLOTS-1:0] tree_reg;
    logic [NUM_SLOTS-1:0] freed_reg;

    // Result registers
    logic [1:0]           status_reg;
    logic [3:0]           new_index_reg;
    logic [15:0]          freed_mask_reg;

    logic [IDX_W-1:0]     tgt_wide;
    logic [SLOT_W-1:0]    tgt_idx;
    logic                 in_range;
    logic                 present;
    logic [NUM_SLOTS-1:0] free_onehot;
    logic [SLOT_W-1:0]    free_idx;
    logic [IDX_W-1:0]     free_wide;
    logic                 full;
    logic [NUM_SLOTS-1:0] grow;
    logic [MASK_W-1:0]    freed_wide;
    logic [MASK_W-1:0]    used_wide;

    // Target decode
    assign tgt_wide = IDX_W'(tgt_reg);
    assign tgt_idx  = tgt_wide[SLOT_W-1:0];
    assign in_range = ({28'd0, tgt_reg} < 32'(NUM_SLOTS));
    assign present  = in_range && used_reg[tgt_idx];

    // Lowest free slot: isolate the lowest zero bit, then encode it
    assign free_onehot = ~used_reg & (used_reg + NUM_SLOTS'(1));
    assign full        = &used_reg;
    always_comb
    begin
        free_idx = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (free_onehot[s])
            begin
                free_idx = free_idx | SLOT_W'(s);
            end
        end
    end
    assign free_wide = IDX_W'(free_idx);

    // One closure pass: used slots, other than the target and those already freed, whose parent is already in the tree
    always_comb
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            grow[s] = used_reg[s] && (SLOT_W'(s) != tgt_idx) && !freed_reg[s]
                      && tree_reg[parent_reg[s]];
        end
    end

    // Fold slot vectors onto the 16-bit result mask
    assign freed_wide = MASK_W'(freed_reg);
    assign used_wide  = MASK_W'(used_reg);

    // Used marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                OP_INIT:
                begin
                    used_reg <= NUM_SLOTS'(1);
                end
                OP_CREATE:
                begin
                    if (present && !full)
                    begin
                        used_reg <= used_reg | free_onehot;
                    end
                end
                OP_CLEAR:
                begin
                    used_reg <= '0;
                end
                default:
                begin
                    used_reg <= used_reg;
                end
            endcase
        end
        else if (cmd.commit)
        begin
            used_reg <= used_reg & ~freed_reg;
        end
    end

    // Parent table, command latch, closure sets and results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode_t'(opcode);
            tgt_reg <= target_index;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_INIT:
                begin
                    status_reg     <= ST_OK;
                    new_index_reg  <= '0;
                    freed_mask_reg <= '0;
                    parent_reg[0]  <= '0;
                end
                OP_CREATE:
                begin
                    freed_mask_reg <= '0;
                    if (!present)
                    begin
                        status_reg    <= ST_NOT_PRESENT;
                        new_index_reg <= '0;
                    end
                    else if (full)
                    begin
                        status_reg    <= ST_FULL;
                        new_index_reg <= '0;
                    end
                    else
                    begin
                        status_reg           <= ST_OK;
                        parent_reg[free_idx] <= tgt_idx;
                        new_index_reg        <= free_wide[3:0];
                    end
                end
                OP_DESTROY:
                begin
                    status_reg     <= present ? ST_OK : ST_NOT_PRESENT;
                    new_index_reg  <= '0;
                    freed_mask_reg <= '0;
                    tree_reg       <= NUM_SLOTS'(1) << tgt_idx;
                    freed_reg      <= '0;
                end
                OP_CLEAR:
                begin
                    status_reg     <= ST_OK;
                    new_index_reg  <= '0;
                    freed_mask_reg <= used_wide[15:0];
                end
                default:
                begin
                    status_reg     <= ST_OK;
                    new_index_reg  <= '0;
                    freed_mask_reg <= '0;
                end
            endcase
        end

        if (cmd.close_step)
        begin
            tree_reg  <= tree_reg | grow;
            freed_reg <= freed_reg | grow;
        end

        if (cmd.commit)
        begin
            status_reg     <= ST_OK;
            new_index_reg  <= '0;
            freed_mask_reg <= freed_wide[15:0];
        end
    end

    assign stat.op      = op_reg;
    assign stat.present = present;
    assign stat.grew    = |grow;

    assign status     = status_reg;
    assign new_index  = new_index_reg;
    assign freed_mask = freed_mask_reg;

endmodule

/* sv/ptsa_checker.sv */
// Port-level checker for the process tree slot allocator, bound to the
// top level. Depends on ptsa_pkg for the status codes.
`timescale 1ns / 1ps

module ptsa_checker
    import ptsa_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status
);

    // An accepted command makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command transfer did not raise busy");

    // A result only appears while a command is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without a command in flight");

    // Exactly one result per command: done is not held high
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Busy drops only right after the result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    // Status carries a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_NOT_PRESENT || status == ST_FULL))
        else $error("undefined status code");

endmodule

bind process_tree_slot_allocator ptsa_checker u_ptsa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status)
);
